@@ rtl/adcpwm_pkg.sv @@
// Shared types, constants and the servo pulse table for the ADC-average to PWM block.
// Used by the lane, merge, top level and checker files; depends on nothing.
`timescale 1ns / 1ps

package adcpwm_pkg;

    localparam int WINDOW_LENGTH = 10;
    localparam int SLOT_W        = $clog2(WINDOW_LENGTH);
    localparam int SAMPLE_W      = 10;
    localparam int SUM_W         = 14;
    localparam int SAMPLE_MAX    = 1023;

    // floor(sum / WINDOW_LENGTH) as a round-up reciprocal multiply, exact for SUM_W-bit sums
    localparam int AVG_K   = SUM_W + $clog2(WINDOW_LENGTH);
    localparam int AVG_M_W = AVG_K + 1;
    localparam int AVG_M   = ((2 ** AVG_K) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;

    localparam int SCALE_W      = 8;
    localparam int OFFSET_W     = 7;
    localparam int SETTING_W    = 8;
    localparam int SPEED_SCALE  = 198;
    localparam int SPEED_OFFSET = 99;
    localparam int ANGLE_SCALE  = 180;
    localparam int ANGLE_OFFSET = 90;

    // floor(prod / 1023) as a round-up reciprocal multiply, exact for PROD_W-bit products
    localparam int PROD_W     = SAMPLE_W + SCALE_W;
    localparam int FULL_SCALE = 1023;
    localparam int FS_K       = PROD_W + $clog2(FULL_SCALE);
    localparam int FS_M_W     = PROD_W + 1;
    localparam int FS_M       = ((2 ** FS_K) + FULL_SCALE - 1) / FULL_SCALE;
    localparam int Q_W        = 8;

    localparam int MAG_W        = 7;
    localparam int DUTY_W       = 11;
    localparam int DUTY_FACTOR  = 20;
    localparam int PULSE_W      = 12;
    localparam int PULSE_GAIN   = 1124;
    localparam int PULSE_SPAN   = 90;
    localparam int PULSE_CENTER = 1874;
    localparam int ANGLE_IDX_W  = $clog2(2 * ANGLE_OFFSET + 1);

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic              load;
        logic [SLOT_W-1:0] slot;
        logic              avg_en;
        logic              prod_en;
        logic              set_en;
    } lane_ctrl_t;

    typedef struct packed {
        logic [PULSE_W-1:0]          servo_pulse;
        logic [DUTY_W-1:0]           motor_duty;
        logic                        bridge_standby;
        logic                        bridge_in2;
        logic                        bridge_in1;
        logic signed [SETTING_W-1:0] angle_setting;
        logic [MAG_W-1:0]            abs_speed;
        logic signed [SETTING_W-1:0] speed_setting;
    } result_t;

    typedef logic [PULSE_W-1:0] pulse_table_t [0:2*ANGLE_OFFSET];

    // servo compare value per angle; integer division truncates toward zero
    function automatic pulse_table_t build_pulse_table();
        pulse_table_t tbl;
        int           a;
        for (int i = 0; i <= 2 * ANGLE_OFFSET; i++)
        begin
            a      = i - ANGLE_OFFSET;
            tbl[i] = PULSE_W'((PULSE_GAIN * a) / PULSE_SPAN + PULSE_CENTER);
        end
        return tbl;
    endfunction

    localparam pulse_table_t PULSE_TABLE = build_pulse_table();

endpackage

@@ rtl/adcpwm_lane.sv @@
// One channel lane: sliding window, running sum, average and scaling to a signed setting.
// Depends on adcpwm_pkg.
`timescale 1ns / 1ps

module adcpwm_lane (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  adcpwm_pkg::lane_ctrl_t                   ctrl,
    input  logic [adcpwm_pkg::SAMPLE_W-1:0]          sample,
    input  logic [adcpwm_pkg::SCALE_W-1:0]           scale,
    input  logic [adcpwm_pkg::OFFSET_W-1:0]          offset,
    output logic signed [adcpwm_pkg::SETTING_W-1:0]  setting
);

    logic [adcpwm_pkg::SAMPLE_W-1:0] window_reg [adcpwm_pkg::WINDOW_LENGTH];
    logic [adcpwm_pkg::SUM_W-1:0]    sum_reg;
    logic [adcpwm_pkg::SUM_W-1:0]    sum_next;
    logic [adcpwm_pkg::SAMPLE_W-1:0] avg_reg;
    logic [adcpwm_pkg::SAMPLE_W-1:0] avg_next;
    logic [adcpwm_pkg::PROD_W-1:0]   prod_reg;
    logic [adcpwm_pkg::PROD_W-1:0]   prod_next;
    logic signed [adcpwm_pkg::SETTING_W-1:0] setting_reg;
    logic signed [adcpwm_pkg::SETTING_W-1:0] setting_next;

    logic [adcpwm_pkg::SUM_W+adcpwm_pkg::AVG_M_W-1:0]  avg_prod;
    logic [adcpwm_pkg::SUM_W-1:0]                      avg_q;
    logic [adcpwm_pkg::PROD_W+adcpwm_pkg::FS_M_W-1:0]  fs_prod;
    logic [adcpwm_pkg::Q_W-1:0]                        q;
    logic signed [adcpwm_pkg::SETTING_W:0]             diff;

    // drop the oldest sample, add the new one
    assign sum_next = adcpwm_pkg::SUM_W'(sum_reg - adcpwm_pkg::SUM_W'(window_reg[ctrl.slot])
                      + adcpwm_pkg::SUM_W'(sample));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            for (int i = 0; i < adcpwm_pkg::WINDOW_LENGTH; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (ctrl.load)
        begin
            sum_reg                <= sum_next;
            window_reg[ctrl.slot]  <= sample;
        end
    end

    assign avg_prod = adcpwm_pkg::SUM_W'(sum_reg)
                      * adcpwm_pkg::AVG_M_W'(adcpwm_pkg::AVG_M);
    assign avg_q    = avg_prod[adcpwm_pkg::AVG_K +: adcpwm_pkg::SUM_W];

    always_comb
    begin
        if (avg_q > adcpwm_pkg::SUM_W'(adcpwm_pkg::SAMPLE_MAX))
        begin
            avg_next = adcpwm_pkg::SAMPLE_W'(adcpwm_pkg::SAMPLE_MAX);
        end
        else
        begin
            avg_next = avg_q[adcpwm_pkg::SAMPLE_W-1:0];
        end
    end

    assign prod_next = adcpwm_pkg::PROD_W'(avg_reg) * adcpwm_pkg::PROD_W'(scale);

    assign fs_prod = adcpwm_pkg::PROD_W'(prod_reg) * adcpwm_pkg::FS_M_W'(adcpwm_pkg::FS_M);
    assign q       = fs_prod[adcpwm_pkg::FS_K +: adcpwm_pkg::Q_W];
    assign diff    = $signed({1'b0, q}) - $signed({2'b00, offset});
    assign setting_next = diff[adcpwm_pkg::SETTING_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.avg_en)
        begin
            avg_reg <= avg_next;
        end
        if (ctrl.prod_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.set_en)
        begin
            setting_reg <= setting_next;
        end
    end

    assign setting = setting_reg;

endmodule

@@ rtl/adcpwm_merge.sv @@
// Merge stage: combines the speed and angle settings into bridge bits, duty and servo pulse,
// and holds the result beat in the output register. Depends on adcpwm_pkg.
`timescale 1ns / 1ps

module adcpwm_merge (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [adcpwm_pkg::SETTING_W-1:0]  speed_setting,
    input  logic signed [adcpwm_pkg::SETTING_W-1:0]  angle_setting,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output adcpwm_pkg::result_t                      result
);

    logic                             valid_reg;
    logic                             valid_next;
    adcpwm_pkg::result_t              result_reg;
    adcpwm_pkg::result_t              result_next;
    logic [adcpwm_pkg::SETTING_W-1:0] neg_speed;
    logic [adcpwm_pkg::MAG_W-1:0]     mag;
    logic [adcpwm_pkg::ANGLE_IDX_W-1:0] angle_idx;

    assign in_ready = !valid_reg || out_ready;

    assign neg_speed = adcpwm_pkg::SETTING_W'(-speed_setting);
    assign mag       = speed_setting[adcpwm_pkg::SETTING_W-1]
                       ? neg_speed[adcpwm_pkg::MAG_W-1:0]
                       : speed_setting[adcpwm_pkg::MAG_W-1:0];
    assign angle_idx = adcpwm_pkg::ANGLE_IDX_W'(angle_setting
                       + adcpwm_pkg::SETTING_W'(adcpwm_pkg::ANGLE_OFFSET));

    always_comb
    begin
        result_next.speed_setting  = speed_setting;
        result_next.abs_speed      = mag;
        result_next.angle_setting  = angle_setting;
        result_next.bridge_in1     = speed_setting[adcpwm_pkg::SETTING_W-1];
        result_next.bridge_in2     = !speed_setting[adcpwm_pkg::SETTING_W-1]
                                     && (speed_setting != '0);
        result_next.bridge_standby = (speed_setting != '0);
        result_next.motor_duty     = adcpwm_pkg::DUTY_W'(mag)
                                     * adcpwm_pkg::DUTY_W'(adcpwm_pkg::DUTY_FACTOR);
        result_next.servo_pulse    = adcpwm_pkg::PULSE_TABLE[angle_idx];
    end

    always_comb
    begin
        priority if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

@@ rtl/adc_average_to_motor_servo_pwm.sv @@
// Top level of the ADC-average to motor and servo PWM block: stream ports, sequencing,
// two channel lanes and the merge stage. Depends on adcpwm_pkg, adcpwm_lane, adcpwm_merge.
`timescale 1ns / 1ps

// Each input beat carries a speed and an angle ADC sample. Each goes into its own lane, which
// keeps a 10-sample sliding window (cleared to zero at reset, so early averages read low) and
// turns the window average into a signed setting; the merge stage then derives the H-bridge
// bits, the motor duty and the servo pulse. One result beat follows every input beat. A sample
// pair passes the window and sum registers, then the three registered multiply steps of the
// lane pipeline (average, scale, full-scale division), then the load of the output register;
// the lanes hold one pair at a time, and the next pair is taken as the settings move on.
// The output register lets the next pair enter while an earlier result still waits.
module adc_average_to_motor_servo_pwm (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // speed_sample [9:0], angle_sample [19:10], zero [23:20]
    input  logic [adcpwm_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // speed_setting [7:0], abs_speed [14:8], angle_setting [22:15], bridge_in1 [23],
    // bridge_in2 [24], bridge_standby [25], motor_duty [36:26], servo_pulse [48:37],
    // zero [55:49]
    output logic [adcpwm_pkg::OUT_DATA_W-1:0]    m_tdata
);

    logic                          v1_reg, v1_next;
    logic                          v2_reg, v2_next;
    logic                          v3_reg, v3_next;
    logic                          v4_reg, v4_next;
    logic [adcpwm_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [adcpwm_pkg::SLOT_W-1:0] slot_eff;
    logic                          accept;
    logic                          merge_ready;
    adcpwm_pkg::lane_ctrl_t        ctrl;
    adcpwm_pkg::result_t           result;
    logic signed [adcpwm_pkg::SETTING_W-1:0] speed_setting;
    logic signed [adcpwm_pkg::SETTING_W-1:0] angle_setting;

    // take the next pair as the held settings move into the merge stage
    assign s_tready = !(v1_reg || v2_reg || v3_reg) && (!v4_reg || merge_ready);
    assign accept   = s_tvalid && s_tready;

    // write at slot 0 should the slot ever leave the window
    assign slot_eff  = (int'(slot_reg) >= adcpwm_pkg::WINDOW_LENGTH) ? '0 : slot_reg;
    assign slot_next = (slot_eff == adcpwm_pkg::SLOT_W'(adcpwm_pkg::WINDOW_LENGTH - 1))
                       ? '0 : adcpwm_pkg::SLOT_W'(slot_eff + 1'b1);

    assign v1_next = accept;
    assign v2_next = v1_reg;
    assign v3_next = v2_reg;
    assign v4_next = v4_reg ? !merge_ready : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            slot_reg <= '0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            if (accept)
            begin
                slot_reg <= slot_next;
            end
        end
    end

    always_comb
    begin
        ctrl.load    = accept;
        ctrl.slot    = slot_eff;
        ctrl.avg_en  = v1_reg;
        ctrl.prod_en = v2_reg;
        ctrl.set_en  = v3_reg;
    end

    adcpwm_lane u_speed_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .sample  (s_tdata[adcpwm_pkg::SAMPLE_W-1:0]),
        .scale   (adcpwm_pkg::SCALE_W'(adcpwm_pkg::SPEED_SCALE)),
        .offset  (adcpwm_pkg::OFFSET_W'(adcpwm_pkg::SPEED_OFFSET)),
        .setting (speed_setting)
    );

    adcpwm_lane u_angle_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .sample  (s_tdata[2*adcpwm_pkg::SAMPLE_W-1:adcpwm_pkg::SAMPLE_W]),
        .scale   (adcpwm_pkg::SCALE_W'(adcpwm_pkg::ANGLE_SCALE)),
        .offset  (adcpwm_pkg::OFFSET_W'(adcpwm_pkg::ANGLE_OFFSET)),
        .setting (angle_setting)
    );

    // the lane setting registers hold while v4 waits for the merge stage
    adcpwm_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (v4_reg),
        .in_ready      (merge_ready),
        .speed_setting (speed_setting),
        .angle_setting (angle_setting),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .result        (result)
    );

    assign m_tdata = {{(adcpwm_pkg::OUT_DATA_W - $bits(adcpwm_pkg::result_t)){1'b0}}, result};

endmodule

@@ rtl/adcpwm_checker.sv @@
// Port-level checker for the ADC-average to PWM top level, with its bind statement.
// Depends on adcpwm_pkg and the top level's ports.
`timescale 1ns / 1ps

module adcpwm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [adcpwm_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic in_beat;

    assign in_beat = s_tvalid && s_tready;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one pair at a time: s_tready stays low while a taken pair is in the v1, v2 and v3 stages
    a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input beat taken while a pair is in flight");

    // bridge bits follow the sign of the speed setting
    a_bridge: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23] == m_tdata[7])
                     && (m_tdata[25] == (m_tdata[23] || m_tdata[24]))
                     && !(m_tdata[23] && m_tdata[24])
                     && (m_tdata[25] == (m_tdata[7:0] != 8'd0)))
        else $error("bridge bits disagree with speed setting");

    // duty tracks the speed magnitude
    a_duty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[36:26] == adcpwm_pkg::DUTY_W'(m_tdata[14:8]
                     * adcpwm_pkg::DUTY_W'(adcpwm_pkg::DUTY_FACTOR)))
        else $error("motor duty disagrees with abs speed");

endmodule

bind adc_average_to_motor_servo_pwm adcpwm_checker u_adcpwm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ dv/tb_adc_average_to_motor_servo_pwm.sv @@
// Self-checking bench for adc_average_to_motor_servo_pwm: random idling on both streams,
// with each result beat checked against an in-bench sliding-average and PWM predictor.
// Depends on adcpwm_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_adc_average_to_motor_servo_pwm;

    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1750;
    localparam int QUIET_ITEMS  = 250;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int PAUSE_AT     = 900;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE       = 16;
    localparam int SMP_W        = adcpwm_pkg::SAMPLE_W;
    localparam int SMP_MAX      = adcpwm_pkg::SAMPLE_MAX;
    localparam int WIN_LEN      = adcpwm_pkg::WINDOW_LENGTH;
    localparam int RES_W        = $bits(adcpwm_pkg::result_t);
    localparam int PAD_W        = adcpwm_pkg::OUT_DATA_W - RES_W;

    class pwm_scoreboard;
        logic [SMP_W-1:0]                speed_hist [WIN_LEN];
        logic [SMP_W-1:0]                angle_hist [WIN_LEN];
        logic [3:0]                      next_slot;
        logic [adcpwm_pkg::SUM_W-1:0]    speed_total;
        logic [adcpwm_pkg::SUM_W-1:0]    angle_total;
        adcpwm_pkg::result_t             expected_q [$];
        int                              mismatches;
        int                              pairs_taken;
        int                              beats_checked;
        int                              forward_cnt;
        int                              reverse_cnt;
        int                              stop_cnt;
        int                              pulse_lo;
        int                              pulse_hi;

        function new();
            for (int k = 0; k < WIN_LEN; k++)
            begin
                speed_hist[k] = '0;
                angle_hist[k] = '0;
            end
            next_slot   = '0;
            speed_total = '0;
            angle_total = '0;
            pulse_lo    = 1 << 30;
            pulse_hi    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // push one sample pair into the windows and queue the result it produces
        function void take_samples(logic [SMP_W-1:0] spd, logic [SMP_W-1:0] ang);
            int                  idx;
            int                  avg_s;
            int                  avg_a;
            int                  speed;
            int                  angle;
            int                  mag;
            int                  pulse;
            adcpwm_pkg::result_t want;
            idx = (next_slot >= WIN_LEN) ? 0 : int'(next_slot);
            speed_total     = speed_total - speed_hist[idx] + spd;
            angle_total     = angle_total - angle_hist[idx] + ang;
            speed_hist[idx] = spd;
            angle_hist[idx] = ang;
            idx = idx + 1;
            if (idx >= WIN_LEN)
                idx = 0;
            next_slot = 4'(idx);

            avg_s = int'(speed_total) / WIN_LEN;
            avg_a = int'(angle_total) / WIN_LEN;
            if (avg_s > SMP_MAX)
                avg_s = SMP_MAX;
            if (avg_a > SMP_MAX)
                avg_a = SMP_MAX;
            speed = (avg_s * 198) / 1023 - 99;
            angle = (avg_a * 180) / 1023 - 90;
            mag   = (speed < 0) ? -speed : speed;
            pulse = (1124 * angle) / 90 + 1874;

            want.speed_setting  = adcpwm_pkg::SETTING_W'(speed);
            want.abs_speed      = adcpwm_pkg::MAG_W'(mag);
            want.angle_setting  = adcpwm_pkg::SETTING_W'(angle);
            want.bridge_in1     = (speed < 0);
            want.bridge_in2     = (speed > 0);
            want.bridge_standby = (speed != 0);
            want.motor_duty     = adcpwm_pkg::DUTY_W'(20 * mag);
            want.servo_pulse    = adcpwm_pkg::PULSE_W'(pulse);
            expected_q.push_back(want);

            pairs_taken++;
            if (speed > 0)
                forward_cnt++;
            else if (speed < 0)
                reverse_cnt++;
            else
                stop_cnt++;
            if (pulse < pulse_lo)
                pulse_lo = pulse;
            if (pulse > pulse_hi)
                pulse_hi = pulse;
        endfunction

        function void check_beat(logic [adcpwm_pkg::OUT_DATA_W-1:0] beat);
            adcpwm_pkg::result_t want;
            adcpwm_pkg::result_t got;
            logic [PAD_W-1:0]    pad;
            got = adcpwm_pkg::result_t'(beat[RES_W-1:0]);
            pad = beat[adcpwm_pkg::OUT_DATA_W-1:RES_W];
            beats_checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result error: beat %0d arrived with nothing pending, data %h",
                             beats_checked, beat);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want || pad !== '0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result error at beat %0d:", beats_checked);
                    $display("  exp speed %0d abs %0d angle %0d in1/in2/stby %b%b%b",
                             want.speed_setting, want.abs_speed, want.angle_setting,
                             want.bridge_in1, want.bridge_in2, want.bridge_standby);
                    $display("      duty %0d pulse %0d", want.motor_duty, want.servo_pulse);
                    $display("  act speed %0d abs %0d angle %0d in1/in2/stby %b%b%b",
                             got.speed_setting, got.abs_speed, got.angle_setting,
                             got.bridge_in1, got.bridge_in2, got.bridge_standby);
                    $display("      duty %0d pulse %0d pad %h",
                             got.motor_duty, got.servo_pulse, pad);
                end
            end
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [adcpwm_pkg::IN_DATA_W-1:0]    s_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [adcpwm_pkg::OUT_DATA_W-1:0]   m_tdata;

    pwm_scoreboard board;
    bit            hold_req;
    bit            quiet;
    bit            stim_done;
    int            stall_cycles;

    adc_average_to_motor_servo_pwm u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // offer one sample pair and hold it until the beat is taken
    task automatic send_pair(input logic [SMP_W-1:0] spd, input logic [SMP_W-1:0] ang);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(adcpwm_pkg::IN_DATA_W - 2 * SMP_W){1'b0}}, ang, spd};
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        board.take_samples(spd, ang);
        @(posedge clk);
    endtask

    task automatic idle_source(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // mostly uniform values, sometimes the rails or the middle of the range
    function automatic logic [SMP_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return SMP_W'(SMP_MAX);
        else if (r <= 3)
            return SMP_W'($urandom_range(500, 525));
        return SMP_W'($urandom_range(0, SMP_MAX));
    endfunction

    function automatic logic [SMP_W-1:0] near(int target);
        int v;
        v = target + $urandom_range(0, 6) - 3;
        if (v < 0)
            v = 0;
        if (v > SMP_MAX)
            v = SMP_MAX;
        return SMP_W'(v);
    endfunction

    // result side: random stalls, one long hold-off on request, steady ready at the end
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        while (!stim_done)
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
        m_tready <= 1'b1;
    end

    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid && m_tready)
            board.check_beat(m_tdata);
    end

    always @(negedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("adc_average_to_motor_servo_pwm: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int               sent;
        int               run_len;
        int               tgt_s;
        int               tgt_a;
        bit               steady;
        logic [SMP_W-1:0] spd;
        logic [SMP_W-1:0] ang;
        board     = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        hold_req  = 1'b0;
        quiet     = 1'b0;
        stim_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // start-up from cleared windows, then full scale, then the stop point, then bit patterns and rails
        send_pair('0, '0);
        repeat (WIN_LEN) send_pair(SMP_W'(SMP_MAX), SMP_W'(SMP_MAX));
        repeat (WIN_LEN) send_pair(SMP_W'(514), SMP_W'(512));
        send_pair(SMP_W'('h2AA), SMP_W'('h155));
        send_pair(SMP_W'('h155), SMP_W'('h2AA));
        send_pair('0, SMP_W'(SMP_MAX));

        // runs either settle on a target (so the average gets there) or are pure noise
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady  = ($urandom_range(0, 3) != 0);
            run_len = $urandom_range(10, 24);
            tgt_s   = ($urandom_range(0, 2) == 0) ? $urandom_range(508, 520)
                                                  : $urandom_range(0, SMP_MAX);
            tgt_a   = $urandom_range(0, SMP_MAX);
            for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++)
            begin
                quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
                if (sent == HOLD_AT)
                    hold_req = 1'b1;
                if (sent == PAUSE_AT)
                begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                    @(posedge clk);
                end
                else if (!quiet && $urandom_range(0, 5) == 0)
                    idle_source($urandom_range(1, 18));
                spd = steady ? near(tgt_s) : pick_sample();
                ang = steady ? near(tgt_a) : pick_sample();
                send_pair(spd, ang);
                sent++;
            end
        end
        s_tvalid  <= 1'b0;
        stim_done = 1'b1;

        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("ran %0d sample pairs, %0d results checked: %0d forward, %0d reverse, %0d stop",
                 board.pairs_taken, board.beats_checked, board.forward_cnt,
                 board.reverse_cnt, board.stop_cnt);
        $display("servo compare values seen from %0d to %0d, %0d result errors",
                 board.pulse_lo, board.pulse_hi, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("adc_average_to_motor_servo_pwm: match");
        else
            $display("adc_average_to_motor_servo_pwm: mismatch");
        $finish;
    end

endmodule
